[src/tripwire_alarm_keypad_disarm_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tripwire alarm core
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TRIPWIRE_ALARM_KEYPAD_DISARM_CORE_ASSERT_SVH
`define TRIPWIRE_ALARM_KEYPAD_DISARM_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define TADC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define TADC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TADC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TADC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[src/tadc_pkg.sv]
// ----------------------------------------------------------------------------
// tadc_pkg
// Shared constants, types and the keypad decode table of the alarm core.
// ----------------------------------------------------------------------------
package tadc_pkg;

    localparam int          PIN_LENGTH_DEFAULT = 4;
    localparam int          THR_W              = 10;
    localparam int          PIN_W              = 16;
    localparam logic [9:0]  THR_RESET          = 10'd50;
    localparam logic [15:0] PIN_RESET          = 16'd9558;

    // Item kinds carried on the input tuser bit.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_KEY    = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_TRIP_THRESHOLD = 1'b0;
    localparam logic CFG_PIN_CODE       = 1'b1;

    typedef enum logic [2:0] {
        KEY_DIGIT,
        KEY_ENTER,
        KEY_BACK,
        KEY_IGNORED,
        KEY_NONE
    } t_key_kind;

    typedef struct packed {
        t_key_kind  kind;
        logic [3:0] digit;
    } t_key;

    // Command word from the alarm control to the PIN entry store.
    typedef struct packed {
        logic       clr;
        logic       push;
        logic       pop;
        logic [3:0] digit;
    } t_entry_cmd;

    function automatic t_key key_decode(input logic [1:0] row, input logic [1:0] col);
        t_key k;
        k.kind  = KEY_DIGIT;
        k.digit = 4'd0;
        unique case ({row, col})
            4'h0: k.kind  = KEY_ENTER;
            4'h1: k.digit = 4'd7;
            4'h2: k.digit = 4'd4;
            4'h3: k.digit = 4'd1;
            4'h4: k.digit = 4'd0;
            4'h5: k.digit = 4'd8;
            4'h6: k.digit = 4'd5;
            4'h7: k.digit = 4'd2;
            4'h8: k.kind  = KEY_NONE;
            4'h9: k.digit = 4'd9;
            4'hA: k.digit = 4'd6;
            4'hB: k.digit = 4'd3;
            4'hC: k.kind  = KEY_IGNORED;
            4'hD: k.kind  = KEY_BACK;
            4'hE: k.kind  = KEY_NONE;
            4'hF: k.kind  = KEY_NONE;
            default: k.kind = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

[src/tadc_pin_entry.sv]
// ----------------------------------------------------------------------------
// tadc_pin_entry
// PIN entry store: digit registers, fill count and compare with the PIN.
// ----------------------------------------------------------------------------
module tadc_pin_entry #(
    parameter int PIN_LENGTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tadc_pkg::t_entry_cmd i_cmd,
    input  logic [15:0]         i_pin_code,
    output logic                o_match,
    output logic [2:0]          o_count_next
);
    import tadc_pkg::*;

    localparam int CW = $clog2(PIN_LENGTH + 1);
    localparam int IW = (PIN_LENGTH > 1) ? $clog2(PIN_LENGTH) : 1;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [3:0]           r_digit [PIN_LENGTH];
    logic [31:0]          pin_wide;
    logic [PIN_LENGTH-1:0] nib_eq;
    logic                 full;

    // Nibbles above the register read as zero.
    assign pin_wide = {16'd0, i_pin_code};
    assign full     = (r_count == CW'(PIN_LENGTH));

    // First digit sits in the highest used nibble.
    always_comb begin
        for (int i = 0; i < PIN_LENGTH; i++) begin
            nib_eq[i] = (r_digit[i] == pin_wide[4*(PIN_LENGTH-1-i) +: 4]);
        end
    end

    assign o_match = full && (&nib_eq);

    always_comb begin
        priority if (i_cmd.clr) begin
            n_count = '0;
        end else if (i_cmd.push && !full) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop && (r_count != '0)) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    assign o_count_next = 3'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_digit[r_count[IW-1:0]] <= i_cmd.digit;
        end
    end

endmodule

[src/tripwire_alarm_keypad_disarm_core.sv]
// ----------------------------------------------------------------------------
// tripwire_alarm_keypad_disarm_core
// Beam-break alarm with keypad PIN disarm, one result word per input word.
// ----------------------------------------------------------------------------
// Every input word is either a light sample (tuser = 0) or a key press given
// as keypad row and column (tuser = 1), and every input word yields exactly
// one result word. While monitoring, a sample above trip_threshold trips the
// alarm, turns the buzzer on and clears the PIN entry. While the alarm is on,
// digit keys fill the entry, backspace removes the last digit, and enter
// compares the entry with pin_code: a full, matching entry disarms the alarm,
// anything else flags a rejection and clears the entry. The block takes one
// word per clock cycle at full rate; a word passes first through the input
// register and then through the result register, and the alarm and entry
// state are updated in the same cycle a word moves from one to the other, so
// consecutive words see each other's effect with no gap. A stalled result
// stalls the input side only when both registers are full. Configuration
// writes are always accepted and take effect on the next word; they should
// be made only while no word is in flight. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
`include "tripwire_alarm_keypad_disarm_core_assert.svh"

module tripwire_alarm_keypad_disarm_core #(
    parameter int PIN_LENGTH = tadc_pkg::PIN_LENGTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] light_sample, [11:10] key_row, [13:12] key_col, [15:14] zero
    input  logic [15:0] s_axis_tdata,
    // [0] cmd
    input  logic [0:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] buzzer_on, [1] tripped_now, [4:2] digits_entered, [5] pin_rejected,
    // [6] disarmed_now, [7] zero
    output logic [7:0]  m_axis_tdata
);
    import tadc_pkg::*;

    // Configuration registers.
    logic [THR_W-1:0] r_threshold;
    logic [PIN_W-1:0] r_pin_code;

    // Input register.
    logic             r_in_valid;
    logic             r_cmd;
    logic [9:0]       r_sample;
    logic [1:0]       r_row;
    logic [1:0]       r_col;

    // Alarm state and result register.
    logic             r_alarm;
    logic             n_alarm;
    logic             r_out_valid;
    logic [7:0]       r_out_data;

    logic             fire;
    t_key             key;
    logic             trip;
    logic             key_active;
    logic             enter;
    logic             match;
    logic             disarm;
    logic             reject;
    logic [2:0]       count_next;
    t_entry_cmd       entry_cmd;

    // The input register moves on whenever the result register is free or
    // being emptied in this cycle.
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
            r_pin_code  <= PIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TRIP_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_PIN_CODE:       r_pin_code  <= i_cfg_data;
                default:            r_pin_code  <= r_pin_code;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd    <= s_axis_tuser[0];
            r_sample <= s_axis_tdata[9:0];
            r_row    <= s_axis_tdata[11:10];
            r_col    <= s_axis_tdata[13:12];
        end
    end

    // Decode of the held word against the current alarm state.
    assign key        = key_decode(r_row, r_col);
    assign trip       = (r_cmd == CMD_SAMPLE) && !r_alarm && (r_sample > r_threshold);
    assign key_active = (r_cmd == CMD_KEY) && r_alarm;
    assign enter      = key_active && (key.kind == KEY_ENTER);
    assign disarm     = enter && match;
    assign reject     = enter && !match;

    // Entry commands only take effect when the word actually moves on.
    assign entry_cmd.clr   = fire && (trip || enter);
    assign entry_cmd.push  = fire && key_active && (key.kind == KEY_DIGIT);
    assign entry_cmd.pop   = fire && key_active && (key.kind == KEY_BACK);
    assign entry_cmd.digit = key.digit;

    tadc_pin_entry #(
        .PIN_LENGTH (PIN_LENGTH)
    ) u_entry (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (entry_cmd),
        .i_pin_code   (r_pin_code),
        .o_match      (match),
        .o_count_next (count_next)
    );

    always_comb begin
        priority if (trip) begin
            n_alarm = 1'b1;
        end else if (disarm) begin
            n_alarm = 1'b0;
        end else begin
            n_alarm = r_alarm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_alarm <= n_alarm;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {1'b0, disarm, reject, count_next, trip, n_alarm};
        end
    end

    // A trip always leaves the alarm sounding.
    `TADC_ASSERT_NEXT(a_trip_sets_alarm, i_clk, i_rst_n, fire && trip, r_alarm, "trip lost")
    // A reported trip comes with the buzzer on and an empty entry.
    `TADC_ASSERT_NOW(a_trip_word, i_clk, i_rst_n, r_out_valid && r_out_data[1], r_out_data[0] && (r_out_data[4:2] == 3'd0), "bad trip word")
    // A disarm silences the buzzer and empties the entry.
    `TADC_ASSERT_NOW(a_disarm_word, i_clk, i_rst_n, r_out_valid && r_out_data[6], !r_out_data[0] && (r_out_data[4:2] == 3'd0) && !r_out_data[5], "bad disarm word")
    // A rejection keeps the alarm on and empties the entry.
    `TADC_ASSERT_NOW(a_reject_word, i_clk, i_rst_n, r_out_valid && r_out_data[5], r_out_data[0] && (r_out_data[4:2] == 3'd0) && !r_out_data[1], "bad reject word")

endmodule

[verif/tb_tripwire_alarm_keypad_disarm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tripwire_alarm_keypad_disarm_core
// Self-checking bench for the beam-break alarm with keypad PIN disarm.
// ----------------------------------------------------------------------------
// A scoreboard object tracks the alarm flag, the PIN entry and both settings.
// It predicts one status word for every input word the core accepts.
// Each result word is checked field by field against the oldest prediction.
// A directed opener covers the threshold edge, every key class and each
// ignored case. Random disarm attempts, broken entries and noise follow, over
// several threshold and PIN settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_tripwire_alarm_keypad_disarm_core;
    import tadc_pkg::*;

    // Keypad positions as {row, col}, used to build key press words.
    localparam logic [3:0] POS_ENTER   = 4'h0;
    localparam logic [3:0] POS_BACK    = 4'hD;
    localparam logic [3:0] POS_IGNORED = 4'hC;
    localparam logic [3:0] POS_BLANK_A = 4'h8;
    localparam logic [3:0] POS_BLANK_B = 4'hE;
    localparam logic [3:0] POS_BLANK_C = 4'hF;

    // Cycles to let pass after the last result before a settings change.
    localparam int SETTLE_CYCLES = 4;
    // Receiver hold-off that lets both internal registers fill up.
    localparam int LONG_HOLD     = 60;
    localparam int DRAIN_LIMIT   = 2000;

    // One result word, laid out exactly as on m_axis_tdata[6:0].
    typedef struct packed {
        logic       disarmed;
        logic       rejected;
        logic [2:0] digits;
        logic       tripped;
        logic       buzzer;
    } t_alarm_status;

    // ------------------------------------------------------------------------
    // Scoreboard: alarm state, settings and the queue of predicted results.
    // ------------------------------------------------------------------------
    class alarm_tracker;
        logic [9:0]    trip_level;
        logic [15:0]   pin_word;
        bit            sounding;
        logic [3:0]    entry [PIN_LENGTH_DEFAULT];
        int unsigned   entry_len;
        t_alarm_status expected_status [$];
        int unsigned   mismatches;
        int unsigned   results_checked;
        int unsigned   trips;
        int unsigned   disarms;
        int unsigned   rejects;

        function new();
            trip_level      = THR_RESET;
            pin_word        = PIN_RESET;
            sounding        = 1'b0;
            entry_len       = 0;
            mismatches      = 0;
            results_checked = 0;
            trips           = 0;
            disarms         = 0;
            rejects         = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] value);
            if (idx == CFG_TRIP_THRESHOLD)
                trip_level = value[9:0];
            else
                pin_word = value;
        endfunction

        // Translate a keypad position into what the key means.
        function void classify_key(logic [1:0] row, logic [1:0] col,
                                   output t_key_kind kind, output logic [3:0] digit);
            kind  = KEY_DIGIT;
            digit = 4'd0;
            case (row)
                2'd0: begin
                    case (col)
                        2'd0: kind = KEY_ENTER;
                        2'd1: digit = 4'd7;
                        2'd2: digit = 4'd4;
                        default: digit = 4'd1;
                    endcase
                end
                2'd1: begin
                    case (col)
                        2'd0: digit = 4'd0;
                        2'd1: digit = 4'd8;
                        2'd2: digit = 4'd5;
                        default: digit = 4'd2;
                    endcase
                end
                2'd2: begin
                    case (col)
                        2'd0: kind = KEY_NONE;
                        2'd1: digit = 4'd9;
                        2'd2: digit = 4'd6;
                        default: digit = 4'd3;
                    endcase
                end
                default: begin
                    case (col)
                        2'd0: kind = KEY_IGNORED;
                        2'd1: kind = KEY_BACK;
                        default: kind = KEY_NONE;
                    endcase
                end
            endcase
        endfunction

        // Only a full entry can match; the first digit sits in the top nibble.
        function bit entry_correct();
            int unsigned i;
            if (entry_len != PIN_LENGTH_DEFAULT)
                return 1'b0;
            for (i = 0; i < PIN_LENGTH_DEFAULT; i++) begin
                if (entry[i] != pin_word[4 * (PIN_LENGTH_DEFAULT - 1 - i) +: 4])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // Apply one accepted input word and queue the status it must produce.
        function void note_word(logic cmd, logic [9:0] sample,
                                logic [1:0] row, logic [1:0] col);
            t_alarm_status st;
            t_key_kind     kind;
            logic [3:0]    digit;
            st = '0;
            if (cmd == CMD_SAMPLE) begin
                if (!sounding && sample > trip_level) begin
                    sounding   = 1'b1;
                    entry_len  = 0;
                    st.tripped = 1'b1;
                    trips++;
                end
            end else if (sounding) begin
                classify_key(row, col, kind, digit);
                case (kind)
                    KEY_ENTER: begin
                        if (entry_correct()) begin
                            sounding    = 1'b0;
                            st.disarmed = 1'b1;
                            disarms++;
                        end else begin
                            st.rejected = 1'b1;
                            rejects++;
                        end
                        entry_len = 0;
                    end
                    KEY_BACK: begin
                        if (entry_len > 0)
                            entry_len = entry_len - 1;
                    end
                    KEY_DIGIT: begin
                        if (entry_len < PIN_LENGTH_DEFAULT) begin
                            entry[entry_len] = digit;
                            entry_len        = entry_len + 1;
                        end
                    end
                    default: ;
                endcase
            end
            st.buzzer = sounding;
            st.digits = entry_len[2:0];
            expected_status.push_back(st);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            if (mismatches <= 100)
                $display("tb: mismatch in %s at result %0d: got %0h, expected %0h",
                         what, results_checked, got, want);
        endtask

        // Compare one accepted result word with the oldest prediction.
        task check_word(logic [7:0] data);
            t_alarm_status want;
            if (expected_status.size() == 0) begin
                report("unexpected result word", data, 16'h0);
                return;
            end
            want = expected_status.pop_front();
            if (data[0] !== want.buzzer)
                report("buzzer_on", data[0], want.buzzer);
            if (data[1] !== want.tripped)
                report("tripped_now", data[1], want.tripped);
            if (data[4:2] !== want.digits)
                report("digits_entered", data[4:2], want.digits);
            if (data[5] !== want.rejected)
                report("pin_rejected", data[5], want.rejected);
            if (data[6] !== want.disarmed)
                report("disarmed_now", data[6], want.disarmed);
            if (data[7] !== 1'b0)
                report("pad bit", data[7], 16'h0);
            results_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, block inputs (all known from time zero) and the core.
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;

    alarm_tracker board;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          hold_off_cycles = 0;
    int unsigned words_sent = 0;
    int unsigned cfg_writes = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    tripwire_alarm_keypad_disarm_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [9:0] light_sample, [11:10] key_row, [13:12] key_col, [15:14] zero
        .s_axis_tdata  (s_axis_tdata),
        // [0] cmd
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] buzzer_on, [1] tripped_now, [4:2] digits_entered,
        // [5] pin_rejected, [6] disarmed_now, [7] zero
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Stimulus tasks. Each one is entered and left right at a rising edge.
    // ------------------------------------------------------------------------

    // Offer one input word after a random gap and wait until it is taken.
    task automatic send_word(input logic cmd, input logic [9:0] sample,
                             input logic [1:0] row, input logic [1:0] col);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, col, row, sample};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_word(cmd, sample, row, col);
        words_sent++;
    endtask

    // The key fields of a sample word and the sample field of a key word are
    // don't-care, so they carry random bits.
    task automatic sample_word(input logic [9:0] value);
        send_word(CMD_SAMPLE, value, 2'($urandom), 2'($urandom));
    endtask

    task automatic key_word(input logic [3:0] pos);
        send_word(CMD_KEY, 10'($urandom), pos[3:2], pos[1:0]);
    endtask

    function automatic logic [3:0] digit_pos(input int d);
        case (d)
            0: return 4'h4;
            1: return 4'h3;
            2: return 4'h7;
            3: return 4'hB;
            4: return 4'h2;
            5: return 4'h6;
            6: return 4'hA;
            7: return 4'h1;
            8: return 4'h5;
            default: return 4'h9;
        endcase
    endfunction

    task automatic digit_key(input int d);
        key_word(digit_pos(d));
    endtask

    // Stop offering words and wait until every predicted result has come,
    // then let the pipeline settle.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (board.expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; valid stays high across the pair.
    task automatic load_settings(input logic [15:0] thr, input logic [15:0] pin);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TRIP_THRESHOLD;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_reg(CFG_TRIP_THRESHOLD, thr);
        i_cfg_index <= CFG_PIN_CODE;
        i_cfg_data  <= pin;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_reg(CFG_PIN_CODE, pin);
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // Trip the beam, then key in the PIN with occasional slips, then enter.
    task automatic disarm_attempt();
        int         lvl;
        int         i;
        logic [3:0] d;
        lvl = int'(board.trip_level);
        if (lvl < 1023)
            sample_word(10'($urandom_range(lvl + 1, 1023)));
        else
            sample_word(10'($urandom));
        if ($urandom_range(0, 3) == 0)
            sample_word(10'($urandom));
        for (i = 0; i < PIN_LENGTH_DEFAULT; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                digit_key($urandom_range(0, 9));
                key_word(POS_BACK);
            end
            d = board.pin_word[4 * (PIN_LENGTH_DEFAULT - 1 - i) +: 4];
            if (d > 4'd9 || $urandom_range(0, 4) == 0)
                d = 4'($urandom_range(0, 9));
            digit_key(d);
        end
        if ($urandom_range(0, 7) == 0)
            digit_key($urandom_range(0, 9));
        key_word(POS_ENTER);
    endtask

    // Partial entries, a sample right at the threshold, stray keys.
    task automatic broken_entry();
        int n;
        int i;
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            digit_key($urandom_range(0, 9));
        case ($urandom_range(0, 3))
            0: key_word(POS_ENTER);
            1: key_word(POS_BACK);
            2: sample_word(board.trip_level);
            default: key_word(4'($urandom));
        endcase
    endtask

    task automatic noise_word();
        send_word(1'($urandom), 10'($urandom), 2'($urandom), 2'($urandom));
    endtask

    task automatic random_episode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            disarm_attempt();
        else if (pick < 80)
            broken_entry();
        else
            noise_word();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready with per-word stalls plus an optional long
    // hold-off that the stimulus requests through hold_off_cycles.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                board.check_word(m_axis_tdata);
                stall_left = rx_idle ? $urandom_range(0, 4) : 0;
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0]  thr_set [6];
        logic [15:0]  pin_set [6];
        int unsigned  phase_end [7];
        int           p;
        int           i;

        board = new();

        // Settings after the default phase; the threshold words carry stray
        // upper bits in some phases, which the core must drop.
        thr_set[0] = 16'h0000;
        pin_set[0] = 16'h0000;
        thr_set[1] = 16'hFFFF;
        pin_set[1] = 16'h9999;
        thr_set[2] = 16'($urandom_range(0, 65535));
        pin_set[2] = 16'hFFFF;
        thr_set[3] = 16'd512;
        pin_set[3] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                      4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        thr_set[4] = 16'($urandom_range(0, 65535));
        pin_set[4] = 16'($urandom_range(0, 65535));
        thr_set[5] = 16'(THR_RESET);
        pin_set[5] = PIN_RESET;
        phase_end = '{300, 600, 700, 1000, 1300, 1600, 1850};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opener under the reset settings (threshold 50, PIN 2556).
        key_word(POS_ENTER);            // key while monitoring does nothing
        sample_word(10'd0);
        sample_word(10'd50);            // equal to the threshold: no trip
        sample_word(10'd51);            // just above: trips
        sample_word(10'd1023);          // sample while sounding is ignored
        key_word(POS_ENTER);            // enter on an empty entry
        key_word(POS_BACK);             // backspace on an empty entry
        digit_key(2);
        key_word(POS_ENTER);            // incomplete entry is rejected
        digit_key(2);
        digit_key(5);
        digit_key(5);
        digit_key(6);
        digit_key(7);                   // entry full: dropped
        key_word(POS_IGNORED);
        key_word(POS_BLANK_A);
        key_word(POS_BLANK_B);
        key_word(POS_BLANK_C);
        key_word(POS_BACK);
        digit_key(6);
        key_word(POS_ENTER);            // correct PIN disarms
        sample_word(10'd1023);
        digit_key(1);
        digit_key(3);
        digit_key(8);
        digit_key(9);
        key_word(POS_ENTER);            // wrong full entry is rejected

        for (p = 0; p < 7; p++) begin
            if (p > 0) begin
                drain_results();
                load_settings(thr_set[p - 1], pin_set[p - 1]);
            end
            // Every third phase runs both streams at full rate.
            tx_idle = (p % 3 != 2);
            rx_idle = (p % 3 != 2);

            if (p == 4) begin
                // The receiver holds off while words keep coming, so the
                // core fills both registers and pushes back on its input.
                hold_off_cycles = LONG_HOLD;
                tx_idle = 1'b0;
                for (i = 0; i < 30; i++)
                    noise_word();
                tx_idle = 1'b1;
            end

            while (words_sent < phase_end[p]) begin
                random_episode();
                // In one phase the sender pauses until nothing is pending.
                if (p == 5 && words_sent >= 1450 && words_sent < 1460)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.expected_status.size() != 0)
            board.report("results never delivered",
                         16'(board.expected_status.size()), 16'h0);

        $display("tb: %0d words sent, %0d results checked, %0d register writes",
                 words_sent, board.results_checked, cfg_writes);
        $display("tb: %0d trips, %0d disarms, %0d rejected entries, %0d mismatches",
                 board.trips, board.disarms, board.rejects, board.mismatches);
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
